@@ sv/smmpc_pkg.sv @@
package smmpc_pkg;

    localparam int COUNT_BITS = 23;
    localparam int PCT_W      = 7;
    localparam int TPP_W      = 16;
    localparam int PROD_W     = PCT_W + TPP_W;
    localparam int MENU_W     = 3;

    localparam logic [TPP_W-1:0] TPP_RESET = TPP_W'(800);
    localparam logic [PCT_W-1:0] FULL_SCALE = PCT_W'(100);

    // Menu positions
    localparam logic [MENU_W-1:0] ST_IDLE  = 3'd0;
    localparam logic [MENU_W-1:0] ST_MODE  = 3'd1;
    localparam logic [MENU_W-1:0] ST_DIR   = 3'd2;
    localparam logic [MENU_W-1:0] ST_SPEED = 3'd3;
    localparam logic [MENU_W-1:0] ST_RUN   = 3'd4;
    localparam logic [MENU_W-1:0] ST_POT   = 3'd5;

    // Item kinds
    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // Menu characters
    localparam logic [7:0] CH_STAR = 8'h2A;
    localparam logic [7:0] CH_T    = 8'h74;
    localparam logic [7:0] CH_P    = 8'h70;
    localparam logic [7:0] CH_H    = 8'h68;
    localparam logic [7:0] CH_A    = 8'h61;
    localparam logic [7:0] CH_S    = 8'h73;

    typedef logic [PCT_W-1:0] pct_t;

    // Percentage for a speed digit, zero when the byte is not one
    function automatic pct_t digit_speed(input logic [7:0] b);
        pct_t res;
        case (b)
            8'h30:   res = PCT_W'(100);
            8'h35:   res = PCT_W'(50);
            8'h36:   res = PCT_W'(60);
            8'h37:   res = PCT_W'(70);
            8'h38:   res = PCT_W'(80);
            8'h39:   res = PCT_W'(90);
            default: res = '0;
        endcase
        return res;
    endfunction

endpackage

@@ sv/serial_menu_motor_pwm_controller_top.sv @@
// Serial menu motor PWM controller.
// Input channel (in_valid/in_ready): each item is either a received serial
// byte (command 0, rx_byte) or one clock tick (command 1). Bytes walk the
// menu; ticks advance the PWM countdown while the motor runs.
// Output channel (out_valid/out_ready): one result item per input item,
// showing bridge levels, enable, menu position, speed, direction and mode
// as they stand after that item.
// An accepted item is first held in the input register, then processed
// and committed to the state registers, which stand as its result.
// Throughput: one item per cycle while the result is taken; the multiply
// that sizes a PWM phase (percent times ticks_per_percent) is combinational.
// A stalled receiver holds the result; the input register still takes one
// more item, after which in_ready drops until the result is taken.
// cfg_we/cfg_wdata write ticks_per_percent; write it only while idle.
// Reset: menu idle, motor stopped, pins low, ticks_per_percent = 800,
// both channels empty.
module serial_menu_motor_pwm_controller_top
    import smmpc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              command,
    input  logic [7:0]        rx_byte,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              drive_cw,
    output logic              drive_ccw,
    output logic              motor_enable,
    output logic [MENU_W-1:0] menu_state,
    output logic [PCT_W-1:0]  speed_percent,
    output logic              direction,
    output logic              control_mode,
    input  logic              cfg_we,
    input  logic [TPP_W-1:0]  cfg_wdata
);

    logic                  s1_valid_reg;
    logic                  s1_cmd_reg;
    logic [7:0]            s1_byte_reg;
    logic                  out_valid_reg;
    logic [TPP_W-1:0]      tpp_reg;

    logic [MENU_W-1:0]     menu_reg,   menu_next;
    logic                  mode_reg,   mode_next;
    logic                  dir_reg,    dir_next;
    pct_t                  speed_reg,  speed_next;
    logic                  level_reg,  level_next;
    logic [1:0]            pins_reg,   pins_next;
    logic                  run_reg,    run_next;
    logic [COUNT_BITS-1:0] remain_reg, remain_next;

    logic                  advance;
    pct_t                  sp;
    pct_t                  pct_sel;
    logic [PROD_W-1:0]     product;
    logic [COUNT_BITS-1:0] span;

    // Stage 1 moves on when the result slot is free or being emptied
    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = !s1_valid_reg || advance;

    assign sp = digit_speed(s1_byte_reg);

    // Phase length percentage: full period unless a real duty phase follows
    always_comb
    begin
        if (s1_cmd_reg == CMD_BYTE || speed_reg == '0 || speed_reg >= FULL_SCALE)
            pct_sel = FULL_SCALE;
        else if (!level_reg)
            pct_sel = speed_reg;
        else
            pct_sel = FULL_SCALE - speed_reg;
    end

    assign product = {{TPP_W{1'b0}}, pct_sel} * {{PCT_W{1'b0}}, tpp_reg};
    assign span    = COUNT_BITS'(product);

    always_comb
    begin
        menu_next   = menu_reg;
        mode_next   = mode_reg;
        dir_next    = dir_reg;
        speed_next  = speed_reg;
        level_next  = level_reg;
        pins_next   = pins_reg;
        run_next    = run_reg;
        remain_next = remain_reg;

        if (s1_cmd_reg == CMD_BYTE)
        begin
            case (menu_reg)
                ST_IDLE:
                begin
                    if (s1_byte_reg == CH_STAR)
                    begin
                        menu_next  = ST_MODE;
                        speed_next = '0;
                    end
                end
                ST_MODE:
                begin
                    if (s1_byte_reg == CH_T)
                    begin
                        mode_next  = 1'b0;
                        speed_next = '0;
                        menu_next  = ST_DIR;
                    end
                    else if (s1_byte_reg == CH_P)
                    begin
                        mode_next  = 1'b1;
                        speed_next = '0;
                        menu_next  = ST_POT;
                    end
                end
                ST_DIR:
                begin
                    if (s1_byte_reg == CH_H || s1_byte_reg == CH_A)
                    begin
                        dir_next   = (s1_byte_reg == CH_A);
                        speed_next = '0;
                        menu_next  = ST_SPEED;
                    end
                end
                ST_SPEED:
                begin
                    if (sp != '0)
                    begin
                        speed_next  = sp;
                        menu_next   = ST_RUN;
                        level_next  = 1'b0;
                        pins_next   = 2'b00;
                        run_next    = 1'b1;
                        remain_next = span;
                    end
                end
                ST_RUN:
                begin
                    if (s1_byte_reg == CH_H)
                        dir_next = 1'b0;
                    else if (s1_byte_reg == CH_A)
                        dir_next = 1'b1;
                    else if (sp != '0)
                        speed_next = sp;
                    else if (s1_byte_reg == CH_S)
                    begin
                        run_next   = 1'b0;
                        speed_next = '0;
                        menu_next  = ST_IDLE;
                    end
                end
                default:
                begin
                    menu_next = menu_reg;
                end
            endcase
        end
        else if (run_reg)
        begin
            if (remain_reg <= COUNT_BITS'(1))
            begin
                // End of phase: pick new level, steer it to the active bridge side
                if (speed_reg == '0)
                    level_next = 1'b0;
                else if (speed_reg >= FULL_SCALE)
                    level_next = 1'b1;
                else
                    level_next = !level_reg;
                pins_next   = dir_reg ? {level_next, 1'b0} : {1'b0, level_next};
                remain_next = span;
            end
            else
            begin
                remain_next = remain_reg - COUNT_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            tpp_reg       <= TPP_RESET;
            menu_reg      <= ST_IDLE;
            mode_reg      <= 1'b0;
            dir_reg       <= 1'b0;
            speed_reg     <= '0;
            level_reg     <= 1'b0;
            pins_reg      <= 2'b00;
            run_reg       <= 1'b0;
            remain_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
                tpp_reg <= cfg_wdata;

            if (in_ready)
                s1_valid_reg <= in_valid;

            if (advance)
                out_valid_reg <= s1_valid_reg;

            // Commit the item's state; it also stands as the result item
            if (advance && s1_valid_reg)
            begin
                menu_reg   <= menu_next;
                mode_reg   <= mode_next;
                dir_reg    <= dir_next;
                speed_reg  <= speed_next;
                level_reg  <= level_next;
                pins_reg   <= pins_next;
                run_reg    <= run_next;
                remain_reg <= remain_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_cmd_reg  <= command;
            s1_byte_reg <= rx_byte;
        end
    end

    assign out_valid     = out_valid_reg;
    assign drive_cw      = pins_reg[0];
    assign drive_ccw     = pins_reg[1];
    assign motor_enable  = run_reg;
    assign menu_state    = menu_reg;
    assign speed_percent = speed_reg;
    assign direction     = dir_reg;
    assign control_mode  = mode_reg;

endmodule
